### design/rne_pkg.sv
package rne_pkg;

	// Largest number that has a numeral
	localparam int unsigned LimitHigh = 3999;

	// ASCII letters of the numerals
	localparam logic [7:0] CH_NONE = 8'h00;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_V    = 8'h56;
	localparam logic [7:0] CH_X    = 8'h58;
	localparam logic [7:0] CH_L    = 8'h4C;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_M    = 8'h4D;

	// Digit places, most significant first
	localparam logic [1:0] PL_THOUSANDS = 2'd0;
	localparam logic [1:0] PL_HUNDREDS  = 2'd1;
	localparam logic [1:0] PL_TENS      = 2'd2;
	localparam logic [1:0] PL_UNITS     = 2'd3;

	// Role of one letter within a digit
	typedef enum logic [1:0] {
		SYM_ONE,
		SYM_FIVE,
		SYM_TEN
	} sym_t;

	// Decimal digits and their letter counts, handed to the emitter
	typedef struct packed {
		logic            oor;
		logic            sub;
		logic [3:0][3:0] digits;
		logic [3:0][2:0] lens;
		logic [1:0]      first;
	} rne_item_t;

	// Number of letters that one digit takes
	function automatic logic [2:0] rne_len(input logic [3:0] d, input logic sub);
		logic [2:0] n;
		if (sub && (d == 4'd4 || d == 4'd9)) begin
			n = 3'd2;
		end else if (d >= 4'd5) begin
			n = 3'(d - 4'd4);
		end else begin
			n = d[2:0];
		end
		return n;
	endfunction

	// Role of the letter at a position within a digit
	function automatic sym_t rne_sym(input logic [3:0] d, input logic sub,
	                                 input logic [2:0] pos);
		sym_t s;
		if (sub && d == 4'd4) begin
			s = (pos == 3'd0) ? SYM_ONE : SYM_FIVE;
		end else if (sub && d == 4'd9) begin
			s = (pos == 3'd0) ? SYM_ONE : SYM_TEN;
		end else if (d >= 4'd5 && pos == 3'd0) begin
			s = SYM_FIVE;
		end else begin
			s = SYM_ONE;
		end
		return s;
	endfunction

	// Letter for a role at a digit place
	function automatic logic [7:0] rne_letter(input logic [1:0] place, input sym_t s);
		logic [7:0] ch;
		ch = CH_NONE;
		case (place)
			PL_THOUSANDS: ch = CH_M;
			PL_HUNDREDS: begin
				case (s)
					SYM_ONE:  ch = CH_C;
					SYM_FIVE: ch = CH_D;
					SYM_TEN:  ch = CH_M;
					default:  ch = CH_NONE;
				endcase
			end
			PL_TENS: begin
				case (s)
					SYM_ONE:  ch = CH_X;
					SYM_FIVE: ch = CH_L;
					SYM_TEN:  ch = CH_C;
					default:  ch = CH_NONE;
				endcase
			end
			PL_UNITS: begin
				case (s)
					SYM_ONE:  ch = CH_I;
					SYM_FIVE: ch = CH_V;
					SYM_TEN:  ch = CH_X;
					default:  ch = CH_NONE;
				endcase
			end
			default: ch = CH_NONE;
		endcase
		return ch;
	endfunction

endpackage

### design/roman_numeral_encoder.sv
// Roman numeral encoder. Each request carries a 16-bit value and a subtractive
// flag; the block answers with the numeral one ASCII letter per result, the
// final letter marked by last. A value of 0 or above 3999 gives a single
// result with char_code 0, last and out_of_range set. The value goes through
// five pipeline stages (range check, thousands, hundreds, tens and units,
// letter counts) into a letter emitter with a registered output. The emitter
// produces one letter per cycle while the receiver takes them, so a number
// gives as many results as its numeral has letters, from 1 to 18 (additive
// 3999); a new request can be taken every cycle while the pipeline has room,
// and the next number's first letter follows the previous number's last with
// no gap.
module roman_numeral_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] value,
	input  logic        subtractive,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_code,
	output logic        last,
	output logic        out_of_range
);
	import rne_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        en1, en2, en3, en4, en5;
	logic        take;

	logic [11:0] val_s1;
	logic        oor_s1, sub_s1;

	logic [1:0]  th_s2;
	logic [9:0]  rem_s2;
	logic        oor_s2, sub_s2;

	logic [3:0]  th_s3, hu_s3;
	logic [6:0]  rem_s3;
	logic        oor_s3, sub_s3;

	logic [3:0]  th_s4, hu_s4, te_s4, un_s4;
	logic        oor_s4, sub_s4;

	rne_item_t   item_s5;

	logic [1:0]  th_c;
	logic [11:0] th_sub;
	logic [15:0] hu_prod;
	logic [3:0]  hu_c;
	logic [10:0] hu_mul;
	logic [13:0] te_prod;
	logic [3:0]  te_c;
	logic [7:0]  te_mul;
	rne_item_t   item_c;

	// Stall chain: a stage moves when it is empty or its content moves on
	assign en5      = !v_s5 || take;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// Stage 1: range check
	always_ff @(posedge clk) begin
		if (en1) begin
			val_s1 <= value[11:0];
			sub_s1 <= subtractive;
			oor_s1 <= (value == 16'd0) || (value > 16'(LimitHigh));
		end
	end

	// Stage 2: thousands digit by compare, an in-range value is below 4000
	always_comb begin
		if (val_s1 >= 12'd3000) begin
			th_c   = 2'd3;
			th_sub = 12'd3000;
		end else if (val_s1 >= 12'd2000) begin
			th_c   = 2'd2;
			th_sub = 12'd2000;
		end else if (val_s1 >= 12'd1000) begin
			th_c   = 2'd1;
			th_sub = 12'd1000;
		end else begin
			th_c   = 2'd0;
			th_sub = 12'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			th_s2  <= th_c;
			rem_s2 <= 10'(val_s1 - th_sub);
			oor_s2 <= oor_s1;
			sub_s2 <= sub_s1;
		end
	end

	// Stage 3: hundreds by reciprocal, exact below 1000
	always_comb begin
		hu_prod = 16'(rem_s2) * 16'd41;
		hu_c    = hu_prod[15:12];
		hu_mul  = 11'(hu_c) * 11'd100;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			th_s3  <= {2'b00, th_s2};
			hu_s3  <= hu_c;
			rem_s3 <= 7'(11'(rem_s2) - hu_mul);
			oor_s3 <= oor_s2;
			sub_s3 <= sub_s2;
		end
	end

	// Stage 4: tens by reciprocal, exact below 100; units as remainder
	always_comb begin
		te_prod = 14'(rem_s3) * 14'd103;
		te_c    = te_prod[13:10];
		te_mul  = 8'(te_c) * 8'd10;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			th_s4  <= th_s3;
			hu_s4  <= hu_s3;
			te_s4  <= te_c;
			un_s4  <= 4'(8'(rem_s3) - te_mul);
			oor_s4 <= oor_s3;
			sub_s4 <= sub_s3;
		end
	end

	// Stage 5: letter counts per digit and the first digit that writes any
	always_comb begin
		item_c.oor       = oor_s4;
		item_c.sub       = sub_s4;
		item_c.digits[0] = th_s4;
		item_c.digits[1] = hu_s4;
		item_c.digits[2] = te_s4;
		item_c.digits[3] = un_s4;
		for (int j = 0; j < 4; j++) begin
			item_c.lens[j] = rne_len(item_c.digits[j], sub_s4);
		end
		item_c.first = PL_UNITS;
		for (int j = 3; j >= 0; j--) begin
			if (item_c.lens[j] != 3'd0) begin
				item_c.first = 2'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			item_s5 <= item_c;
		end
	end

	rne_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (v_s5),
		.item         (item_s5),
		.item_take    (take),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.last         (last),
		.out_of_range (out_of_range)
	);

endmodule

### design/rne_emit.sv
module rne_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  rne_pkg::rne_item_t  item,
	output logic                item_take,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          char_code,
	output logic                last,
	output logic                out_of_range
);
	import rne_pkg::*;

	logic       busy_q;
	rne_item_t  item_q;
	logic [1:0] place_q;
	logic [2:0] pos_q;

	logic       out_v_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       oor_q;

	logic       out_free;
	logic       emit;
	logic [3:0] cur_d;
	logic [2:0] cur_len;
	logic       end_dig;
	logic       found;
	logic [1:0] nxt;
	logic       done;
	logic [7:0] letter;

	// Current letter and where the walk goes next
	always_comb begin
		out_free = !out_v_q || out_ready;
		emit     = busy_q && out_free;
		cur_d    = item_q.digits[place_q];
		cur_len  = item_q.lens[place_q];
		end_dig  = (pos_q + 3'd1) == cur_len;
		letter   = rne_letter(place_q, rne_sym(cur_d, item_q.sub, pos_q));
		found    = 1'b0;
		nxt      = place_q;
		for (int j = 3; j >= 0; j--) begin
			if (j > int'(place_q) && item_q.lens[j] != 3'd0) begin
				found = 1'b1;
				nxt   = 2'(j);
			end
		end
		done      = item_q.oor || (end_dig && !found);
		item_take = item_valid && (!busy_q || (emit && done));
	end

	// Hold the request being spelt out, advance letter by letter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (item_take) begin
			busy_q <= 1'b1;
		end else if (emit && done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_q  <= item;
			place_q <= item.first;
			pos_q   <= 3'd0;
		end else if (emit) begin
			if (end_dig) begin
				place_q <= nxt;
				pos_q   <= 3'd0;
			end else begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	// Output register, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= item_q.oor ? CH_NONE : letter;
			last_q <= done;
			oor_q  <= item_q.oor;
		end
	end

	assign out_valid    = out_v_q;
	assign char_code    = char_q;
	assign last         = last_q;
	assign out_of_range = oor_q;

endmodule

### tb/roman_numeral_encoder_tb.sv
module roman_numeral_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rne_pkg::*;

	// One letter of a numeral as it leaves the block
	typedef struct packed {
		logic [7:0] code;
		logic       last;
		logic       oor;
	} letter_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] value;
	logic        subtractive;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  char_code;
	logic        last;
	logic        out_of_range;

	// Letters still owed by the block, oldest first
	letter_t     letters_due[$];
	int unsigned mismatch_count = 0;

	// Drop all idling on both sides while set
	bit          burst_mode = 1'b0;
	// Ask the receiver for one long hold-off
	bit          hold_off_pending = 1'b0;

	// Letters for one, five and ten, thousands place first
	logic [7:0]  one_glyph  [4] = '{CH_M, CH_C, CH_X, CH_I};
	logic [7:0]  five_glyph [4] = '{CH_M, CH_D, CH_L, CH_V};
	logic [7:0]  ten_glyph  [4] = '{CH_M, CH_M, CH_C, CH_X};
	int unsigned place_div  [4] = '{1000, 100, 10, 1};

	roman_numeral_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.value        (value),
		.subtractive  (subtractive),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.last         (last),
		.out_of_range (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the letters of one accepted request and queue them
	task automatic predict_numeral(input logic [15:0] num, input logic sub);
		letter_t     pending[$];
		int unsigned d;
		if (num < 1 || num > LimitHigh) begin
			letters_due.push_back(letter_t'{code: CH_NONE, last: 1'b1, oor: 1'b1});
			return;
		end
		for (int p = 0; p < 4; p++) begin
			d = (num / place_div[p]) % 10;
			if (sub && d == 4) begin
				pending.push_back(letter_t'{code: one_glyph[p], last: 1'b0, oor: 1'b0});
				pending.push_back(letter_t'{code: five_glyph[p], last: 1'b0, oor: 1'b0});
			end else if (sub && d == 9) begin
				pending.push_back(letter_t'{code: one_glyph[p], last: 1'b0, oor: 1'b0});
				pending.push_back(letter_t'{code: ten_glyph[p], last: 1'b0, oor: 1'b0});
			end else begin
				if (d >= 5)
					pending.push_back(letter_t'{code: five_glyph[p], last: 1'b0, oor: 1'b0});
				for (int k = 0; k < d % 5; k++)
					pending.push_back(letter_t'{code: one_glyph[p], last: 1'b0, oor: 1'b0});
			end
		end
		pending[pending.size() - 1].last = 1'b1;
		foreach (pending[i])
			letters_due.push_back(pending[i]);
	endtask

	// Offer one request after a random gap and hold it until taken
	task automatic offer_number(input logic [15:0] num, input logic sub);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		value       <= num;
		subtractive <= sub;
		do @(posedge clk); while (!in_ready);
		predict_numeral(num, sub);
	endtask

	// Out-of-range values, including every high bit set and cleared
	task automatic test_out_of_range();
		offer_number(16'd0, 1'b0);
		offer_number(16'd0, 1'b1);
		offer_number(16'd4000, 1'b1);
		offer_number(16'hFFFF, 1'b0);
		offer_number(16'h8000, 1'b1);
		offer_number(16'h5555, 1'b0);
		offer_number(16'hAAAA, 1'b1);
	endtask

	// Smallest, largest, fours, nines and single-letter digits in both forms
	task automatic test_directed_numerals();
		logic [15:0] picks[9] = '{16'd1, 16'd3999, 16'd4, 16'd9, 16'd444,
		                          16'd999, 16'd3888, 16'd1000, 16'd2505};
		foreach (picks[i]) begin
			offer_number(picks[i], 1'b0);
			offer_number(picks[i], 1'b1);
		end
	endtask

	// Mostly valid numbers, some anything the field allows
	task automatic test_random_numbers(input int unsigned count);
		logic [15:0] num;
		repeat (count) begin
			if ($urandom_range(0, 99) < 85)
				num = 16'($urandom_range(1, LimitHigh));
			else
				num = 16'($urandom_range(0, 16'hFFFF));
			offer_number(num, 1'($urandom_range(0, 1)));
		end
	endtask

	// Stretch with no idling on either side
	task automatic test_back_to_back();
		burst_mode = 1'b1;
		test_random_numbers(40);
		burst_mode = 1'b0;
	endtask

	// Hold the output off long enough for the pipeline to fill and stall input
	task automatic test_output_stall();
		hold_off_pending = 1'b1;
		burst_mode = 1'b1;
		offer_number(16'd3999, 1'b0);
		offer_number(16'd3888, 1'b0);
		test_random_numbers(30);
		burst_mode = 1'b0;
	endtask

	// Receiver: random stalls per letter, plus the one long hold-off
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			stall = burst_mode ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && !hold_off_pending);
		end
	end

	// Compare each delivered letter with the oldest one owed
	always @(posedge clk) begin
		letter_t want;
		if (arst_n && out_valid && out_ready) begin
			if (letters_due.size() == 0) begin
				$display("%0t: unexpected letter char_code=%h last=%b out_of_range=%b",
				         $time, char_code, last, out_of_range);
				mismatch_count++;
			end else begin
				want = letters_due.pop_front();
				if (char_code !== want.code) begin
					$display("%0t: char_code expected %h actual %h",
					         $time, want.code, char_code);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %b actual %b", $time, want.last, last);
					mismatch_count++;
				end
				if (out_of_range !== want.oor) begin
					$display("%0t: out_of_range expected %b actual %b",
					         $time, want.oor, out_of_range);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		value       = 16'd0;
		subtractive = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_out_of_range();
		test_directed_numerals();
		test_random_numbers(150);
		test_back_to_back();
		test_output_stall();
		test_random_numbers(150);

		// Release the input and let the tail drain
		@(negedge clk);
		in_valid <= 1'b0;
		wait (letters_due.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("%0t: timeout with %0d letters outstanding", $time, letters_due.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
